>>> src/mlrq_pkg.sv
// mlrq_pkg: shared types and constants for the multilevel ready queue scheduler
// no dependencies
package mlrq_pkg;

    localparam int unsigned MAX_PROCS_DEF = 64;
    localparam int unsigned NUM_CLASSES   = 5;
    localparam int unsigned CLASS_W       = 3;
    localparam int unsigned SLICE_W       = 16;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned ID_W          = 6;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

    // operation codes
    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_REM   = 2'd1;
    localparam logic [1:0] OP_YIELD = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    proc_id;
        logic [CLASS_W-1:0] proc_class;
        logic               still_running;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    next_id;
        logic [CLASS_W-1:0] next_class;
        logic [SLICE_W-1:0] slice;
        logic               switched;
    } t_rsp;

endpackage

>>> src/mlrq_if.sv
// mlrq_if: valid/ready channel carrying one payload
// depends on mlrq_pkg for payload types
interface mlrq_if #(parameter type T = mlrq_pkg::t_req);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/multilevel_ready_queue_scheduler_core.sv
// channel  | dir | payload
// i_req    | in  | op, proc_id, proc_class, still_running
// o_rsp    | out | status, next_id, next_class, slice, switched
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data (slice per class)
// A new request is taken only after the response to the last one has been accepted.
// An ignored item goes straight to response; enqueue appends, remove unlinks, yield pops.
// Link memory reads are serialised through one sequencer, one read per cycle, with
// registered read data. Yield with requeue runs an append then a pop.
// Synchronous active-low reset clears the queue and queued flags; the link memories
// are never used before written. The request is not taken while a response waits.
// depends on mlrq_pkg and mlrq_if
module multilevel_ready_queue_scheduler_core #(
    parameter int unsigned MAX_PROCS = mlrq_pkg::MAX_PROCS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mlrq_if.sink   i_req,
    mlrq_if.source o_rsp,
    input  logic                          i_cfg_we,
    input  logic [mlrq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mlrq_pkg::SLICE_W-1:0]   i_cfg_data
);
    localparam int unsigned NC = mlrq_pkg::NUM_CLASSES;
    localparam int unsigned PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned IW = mlrq_pkg::ID_W;
    localparam int unsigned CW = mlrq_pkg::CLASS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_APP, S_APP_W, S_UNL_RD, S_UNL_W, S_PICK, S_RESP
    } t_state;

    // link memories: next, prev, class; single read port each
    logic [PW-1:0] m_next [MAX_PROCS];
    logic [PW-1:0] m_prev [MAX_PROCS];
    logic [CW-1:0] m_cls  [MAX_PROCS];
    logic [MAX_PROCS-1:0] r_queued;

    logic [PW-1:0] r_rd_addr;
    logic [PW-1:0] r_rd_next, r_rd_prev;
    logic [CW-1:0] r_rd_cls;

    logic [mlrq_pkg::SLICE_W-1:0] r_slices [NC];
    logic [PW-1:0] r_head [NC];
    logic [PW-1:0] r_tail [NC];
    logic [NC-1:0] r_nonempty;

    logic [PW-1:0] r_cur_id;
    logic [CW-1:0] r_cur_cls;
    logic          r_cur_valid;

    t_state           r_state;
    mlrq_pkg::t_req   r_req;
    mlrq_pkg::t_rsp   r_rsp;
    logic             r_rsp_valid;
    logic             r_had;
    logic [PW-1:0]    r_prev_id;
    logic [PW-1:0]    r_id;      // process being appended or unlinked
    logic [CW-1:0]    r_cls;
    logic             r_pop;     // unlink is part of a yield pop

    // write ports, one per link memory, driven by the sequencer
    logic          we_next, we_prev, we_cls;
    logic [PW-1:0] wa_next, wa_prev, wa_cls;
    logic [PW-1:0] wd_next, wd_prev;
    logic [CW-1:0] wd_cls;

    logic          id_ok;
    logic [PW-1:0] req_id;
    assign id_ok  = ({{(32-IW){1'b0}}, r_req.proc_id} < MAX_PROCS);
    assign req_id = PW'(r_req.proc_id);

    // first non-empty queue by rank
    logic          any_ready;
    logic [CW-1:0] pick_q;
    always_comb begin
        any_ready = 1'b0;
        pick_q    = '0;
        for (int q = NC - 1; q >= 0; q--) begin
            if (r_nonempty[q]) begin
                any_ready = 1'b1;
                pick_q    = CW'(q);
            end
        end
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // memory reads and writes
    always_ff @(posedge i_clk) begin
        r_rd_next <= m_next[r_rd_addr];
        r_rd_prev <= m_prev[r_rd_addr];
        r_rd_cls  <= m_cls[r_rd_addr];
        if (we_next) m_next[wa_next] <= wd_next;
        if (we_prev) m_prev[wa_prev] <= wd_prev;
        if (we_cls)  m_cls[wa_cls]   <= wd_cls;
    end

    // unlink decisions: whether entry r_id is the head or tail of its class queue
    logic          unl_head, unl_tail;
    assign unl_head = (r_head[r_cls] == r_id);
    assign unl_tail = (r_tail[r_cls] == r_id);

    always_comb begin
        we_next = 1'b0; we_prev = 1'b0; we_cls = 1'b0;
        wa_next = r_id; wa_prev = r_id; wa_cls = r_id;
        wd_next = '0;   wd_prev = '0;   wd_cls = r_cls;
        case (r_state)
            S_APP: begin
                // new tail entry and link from the old tail
                we_prev = 1'b1; wd_prev = r_tail[r_cls];
                we_cls  = 1'b1;
                we_next = r_nonempty[r_cls];
                wa_next = r_tail[r_cls];
                wd_next = r_id;
            end
            S_UNL_W: begin
                // relink neighbours only when the entry really leaves this queue
                if ((r_pop || r_rd_cls == r_cls) && !unl_head) begin
                    we_next = 1'b1; wa_next = r_rd_prev; wd_next = r_rd_next;
                    if (!unl_tail) begin
                        we_prev = 1'b1; wa_prev = r_rd_next; wd_prev = r_rd_prev;
                    end
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_nonempty  <= '0;
            r_queued    <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_cur_cls   <= '0;
            for (int i = 0; i < NC; i++) begin
                r_slices[i] <= mlrq_pkg::SLICE_RESET;
                r_head[i]   <= '0;
                r_tail[i]   <= '0;
            end
        end else begin
            if (i_cfg_we && ({{(32-mlrq_pkg::CFG_IDX_W){1'b0}}, i_cfg_idx} < NC))
                r_slices[i_cfg_idx] <= i_cfg_data;
            if (o_rsp.valid && o_rsp.ready) r_rsp_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req   <= i_req.data;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_rsp     <= '{status: mlrq_pkg::ST_IGNORED, next_id: '0,
                                   next_class: '0, slice: '0, switched: 1'b0};
                    r_pop     <= 1'b0;
                    r_had     <= r_cur_valid;
                    r_prev_id <= r_cur_id;
                    case (r_req.op)
                        mlrq_pkg::OP_ENQ: begin
                            if (id_ok && r_req.proc_class < CW'(NC) && !r_queued[req_id]) begin
                                r_id <= req_id; r_cls <= r_req.proc_class;
                                r_state <= S_APP;
                            end else begin
                                r_state <= S_RESP;
                            end
                        end
                        mlrq_pkg::OP_REM: begin
                            if (id_ok && r_req.proc_class < CW'(NC) && r_queued[req_id]) begin
                                r_id <= req_id; r_cls <= r_req.proc_class;
                                r_rd_addr <= req_id;
                                r_state <= S_UNL_RD;
                            end else begin
                                r_state <= S_RESP;
                            end
                        end
                        mlrq_pkg::OP_YIELD: begin
                            r_cur_valid <= 1'b0;
                            if (r_cur_valid && r_req.still_running && !r_queued[r_cur_id]) begin
                                r_id <= r_cur_id; r_cls <= r_cur_cls;
                                r_state <= S_APP;
                            end else begin
                                r_state <= S_PICK;
                            end
                        end
                        default: r_state <= S_RESP;
                    endcase
                end
                S_APP: begin
                    if (!r_nonempty[r_cls]) r_head[r_cls] <= r_id;
                    r_tail[r_cls]     <= r_id;
                    r_nonempty[r_cls] <= 1'b1;
                    r_queued[r_id]    <= 1'b1;
                    r_state <= S_APP_W;
                end
                S_APP_W: begin
                    if (r_req.op == mlrq_pkg::OP_YIELD) begin
                        r_state <= S_PICK;
                    end else begin
                        r_rsp.status <= mlrq_pkg::ST_DONE;
                        r_state      <= S_RESP;
                    end
                end
                S_PICK: begin
                    if (any_ready) begin
                        r_id <= r_head[pick_q]; r_cls <= pick_q;
                        r_rd_addr <= r_head[pick_q];
                        r_pop <= 1'b1;
                        r_state <= S_UNL_RD;
                    end else begin
                        r_rsp.status <= mlrq_pkg::ST_NONE;
                        r_state <= S_RESP;
                    end
                end
                S_UNL_RD: begin
                    // wait for the registered memory read
                    r_state <= S_UNL_W;
                end
                S_UNL_W: begin
                    if (!r_pop && r_rd_cls != r_cls) begin
                        r_state <= S_RESP;  // queued in another class
                    end else begin
                        if (unl_head) begin
                            if (unl_tail) r_nonempty[r_cls] <= 1'b0;
                            else          r_head[r_cls] <= r_rd_next;
                        end else if (unl_tail) begin
                            r_tail[r_cls] <= r_rd_prev;
                        end
                        r_queued[r_id] <= 1'b0;
                        r_rsp.status <= mlrq_pkg::ST_DONE;
                        if (r_pop) begin
                            r_cur_id <= r_id; r_cur_cls <= r_cls; r_cur_valid <= 1'b1;
                            r_rsp.next_id    <= IW'(r_id);
                            r_rsp.next_class <= r_cls;
                            r_rsp.slice      <= r_slices[r_cls];
                            r_rsp.switched   <= !(r_had && r_prev_id == r_id);
                        end
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_rsp_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no transfer is taken while a response waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> !i_req.ready)
        else $error("request accepted while response pending");
    // a yield that picks leaves a current process
    a_pick_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNL_W && r_pop) |=> r_cur_valid)
        else $error("pop did not set current");
    // the response is valid in the cycle after the response state
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |=> r_rsp_valid)
        else $error("response lost");

endmodule

>>> tb/sv/multilevel_ready_queue_scheduler_core_test.sv
// multilevel_ready_queue_scheduler_core_test: directed table and random scheduling traffic,
// every response compared in full against an in-bench scheduler predictor
// depends on mlrq_pkg, mlrq_if and multilevel_ready_queue_scheduler_core
module multilevel_ready_queue_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDW = mlrq_pkg::ID_W;
    localparam int unsigned CLW = mlrq_pkg::CLASS_W;
    localparam int unsigned SLW = mlrq_pkg::SLICE_W;
    localparam int unsigned CXW = mlrq_pkg::CFG_IDX_W;
    localparam int unsigned NCL = mlrq_pkg::NUM_CLASSES;
    localparam logic [1:0] OP_BAD = 2'd3;
    localparam int N_RAND = 1850;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CXW-1:0] i_cfg_idx;
    logic [SLW-1:0] i_cfg_data;

    mlrq_if #(.T(mlrq_pkg::t_req)) req_ch ();
    mlrq_if #(.T(mlrq_pkg::t_rsp)) rsp_ch ();

    multilevel_ready_queue_scheduler_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [SLW-1:0] slice_tab [NCL];
    bit [IDW-1:0] ready_q [NCL][$];
    bit queued [64];
    bit [CLW-1:0] cls_of [64];
    bit [IDW-1:0] cur_id;
    bit [CLW-1:0] cur_cls;
    bit cur_valid;

    mlrq_pkg::t_rsp sched_expected [$];
    int errors = 0;
    int cycles = 0;
    bit idle_off = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[multilevel_ready_queue_scheduler_core] ERROR");
            $finish;
        end
    end

    function automatic bit sched_append(bit [IDW-1:0] id, bit [CLW-1:0] c);
        if (c >= NCL || queued[id]) return 0;
        ready_q[c].push_back(id);
        queued[id] = 1;
        cls_of[id] = c;
        return 1;
    endfunction

    function automatic void sched_unlink(bit [IDW-1:0] id);
        bit [CLW-1:0] c;
        c = cls_of[id];
        foreach (ready_q[c][k])
            if (ready_q[c][k] == id) begin
                ready_q[c].delete(k);
                break;
            end
        queued[id] = 0;
    endfunction

    function automatic mlrq_pkg::t_rsp sched_predict(mlrq_pkg::t_req r);
        mlrq_pkg::t_rsp o;
        bit had;
        bit [IDW-1:0] prev;
        o = '0;
        o.status = mlrq_pkg::ST_IGNORED;
        if (r.op == mlrq_pkg::OP_ENQ) begin
            if (sched_append(r.proc_id, r.proc_class)) o.status = mlrq_pkg::ST_DONE;
        end else if (r.op == mlrq_pkg::OP_REM) begin
            if (r.proc_class < NCL && queued[r.proc_id] &&
                cls_of[r.proc_id] == r.proc_class) begin
                sched_unlink(r.proc_id);
                o.status = mlrq_pkg::ST_DONE;
            end
        end else if (r.op == mlrq_pkg::OP_YIELD) begin
            had = cur_valid;
            prev = cur_id;
            if (cur_valid && r.still_running) void'(sched_append(cur_id, cur_cls));
            cur_valid = 0;
            o.status = mlrq_pkg::ST_NONE;
            for (int q = 0; q < NCL; q++)
                if (ready_q[q].size() > 0) begin
                    o.next_id = ready_q[q][0];
                    o.next_class = CLW'(q);
                    sched_unlink(o.next_id);
                    cur_id = o.next_id;
                    cur_cls = CLW'(q);
                    cur_valid = 1;
                    o.slice = slice_tab[q];
                    o.switched = (had && prev == o.next_id) ? 1'b0 : 1'b1;
                    o.status = mlrq_pkg::ST_DONE;
                    break;
                end
        end
        return o;
    endfunction

    // response side: random back-pressure, compare on transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) rsp_ch.ready <= 0;
        else rsp_ch.ready <= idle_off || ($urandom_range(99) >= 35);
    end

    always @(posedge i_clk) begin
        mlrq_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (sched_expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected response %p", rsp_ch.data);
            end else begin
                want = sched_expected.pop_front();
                if (rsp_ch.data !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", want, rsp_ch.data);
                end
            end
        end
    end

    // request side: optional idle cycles, then hold the transfer until taken
    task automatic send_req(mlrq_pkg::t_req r, bit chk, mlrq_pkg::t_rsp fixed);
        mlrq_pkg::t_rsp p;
        while (!idle_off && $urandom_range(99) < 35) begin
            req_ch.valid <= 0;
            @(negedge i_clk);
        end
        req_ch.data <= r;
        req_ch.valid <= 1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        p = sched_predict(r);
        if (chk && p !== fixed) begin
            errors++;
            if (errors <= 10) $display("table row: expected %p predicted %p", fixed, p);
        end
        sched_expected.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic drain;
        req_ch.valid <= 0;
        while (sched_expected.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_slice(int idx, logic [SLW-1:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= CXW'(idx);
        i_cfg_data <= v;
        slice_tab[idx] = v;
        @(negedge i_clk);
    endtask

    function automatic mlrq_pkg::t_req mk(logic [1:0] op, int id, int c, bit run);
        mlrq_pkg::t_req r;
        r.op = op;
        r.proc_id = IDW'(id);
        r.proc_class = CLW'(c);
        r.still_running = run;
        return r;
    endfunction

    function automatic mlrq_pkg::t_rsp res(logic [1:0] st, int id, int c, int sl, bit sw);
        mlrq_pkg::t_rsp o;
        o.status = st;
        o.next_id = IDW'(id);
        o.next_class = CLW'(c);
        o.slice = SLW'(sl);
        o.switched = sw;
        return o;
    endfunction

    typedef struct {
        mlrq_pkg::t_req r;
        bit chk;
        mlrq_pkg::t_rsp o;
    } t_row;

    t_row dir_tab [$];

    task automatic rnd_item(int mode);
        mlrq_pkg::t_req r;
        r.op = ($urandom_range(99) < 3) ? OP_BAD : 2'($urandom_range(2));
        r.proc_id = mode ? IDW'($urandom_range(7)) : IDW'($urandom_range(63));
        r.proc_class = ($urandom_range(99) < 8) ? CLW'($urandom_range(7, 5))
                                                : CLW'($urandom_range(4));
        r.still_running = 1'($urandom_range(1));
        if (r.op == mlrq_pkg::OP_REM && queued[r.proc_id] && $urandom_range(1))
            r.proc_class = cls_of[r.proc_id];
        send_req(r, 0, '0);
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        req_ch.valid = 0;
        req_ch.data = '0;
        for (int q = 0; q < NCL; q++) slice_tab[q] = mlrq_pkg::SLICE_RESET;
        cur_valid = 0;
        cur_id = 0;
        cur_cls = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed rows
        dir_tab = '{
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 1), 1, res(mlrq_pkg::ST_NONE, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_ENQ, 63, 4, 0), 1, res(mlrq_pkg::ST_DONE, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_ENQ, 63, 4, 0), 1, res(mlrq_pkg::ST_IGNORED, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_ENQ, 5, 7, 1), 1, res(mlrq_pkg::ST_IGNORED, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_ENQ, 5, 5, 0), 1, res(mlrq_pkg::ST_IGNORED, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_ENQ, 0, 0, 0), 1, res(mlrq_pkg::ST_DONE, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_ENQ, 10, 2, 0), 1, res(mlrq_pkg::ST_DONE, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_REM, 10, 3, 0), 1, res(mlrq_pkg::ST_IGNORED, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_REM, 10, 6, 0), 1, res(mlrq_pkg::ST_IGNORED, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_REM, 11, 2, 0), 1, res(mlrq_pkg::ST_IGNORED, 0, 0, 0, 0)},
            '{mk(OP_BAD, 10, 2, 1), 1, res(mlrq_pkg::ST_IGNORED, 0, 0, 0, 0)},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 1), 1, res(mlrq_pkg::ST_DONE, 0, 0, 10, 1)},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 1), 1, res(mlrq_pkg::ST_DONE, 0, 0, 10, 0)},
            '{mk(mlrq_pkg::OP_ENQ, 0, 0, 0), 0, '0},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 1), 0, '0},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 0), 0, '0},
            '{mk(mlrq_pkg::OP_REM, 10, 2, 0), 0, '0},
            '{mk(mlrq_pkg::OP_ENQ, 20, 1, 1), 0, '0},
            '{mk(mlrq_pkg::OP_ENQ, 21, 1, 0), 0, '0},
            '{mk(mlrq_pkg::OP_ENQ, 22, 1, 0), 0, '0},
            '{mk(mlrq_pkg::OP_REM, 21, 1, 0), 0, '0},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 1), 0, '0},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 1), 0, '0},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 0), 0, '0},
            '{mk(mlrq_pkg::OP_YIELD, 0, 0, 0), 0, '0}
        };
        foreach (dir_tab[k]) send_req(dir_tab[k].r, dir_tab[k].chk, dir_tab[k].o);
        drain();

        // random phases with varied slice settings, extremes among them
        for (int ph = 0; ph < 5; ph++) begin
            for (int q = 0; q < NCL; q++)
                write_slice(q, ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0000 :
                            ph == 2 ? 16'h0001 << q : SLW'($urandom_range(65535)));
            i_cfg_we <= 0;
            idle_off = (ph == 3);
            for (int n = 0; n < N_RAND / 5; n++) rnd_item(ph == 4);
            drain();
        end
        idle_off = 0;

        if (errors == 0) begin
            $display("[multilevel_ready_queue_scheduler_core] OK");
        end else begin
            $display("[multilevel_ready_queue_scheduler_core] ERROR");
        end
        $finish;
    end
endmodule
